[rtl/core/free_list_heap_allocator_assert.svh]
`ifndef FREE_LIST_HEAP_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_HEAP_ALLOCATOR_ASSERT_SVH

// Both macros expect clk and rst_n in scope.
`define FLHA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("free list allocator check failed");

`define FLHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("free list allocator check failed");

`endif

[rtl/core/flha_pkg.sv]
`default_nettype none
package flha_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 8;
  localparam int NODE_BYTES   = 16;
  localparam int AW           = 12;
  localparam int LW           = 13;
  localparam logic [LW-1:0] NULL_LINK  = LW'(HEAP_BYTES);
  localparam logic [LW-1:0] INIT_LEN   = LW'(HEAP_BYTES - NODE_BYTES);

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_BAD_SZ  = 2'd2,
    ST_BAD_PTR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POL_BEST  = 2'd0,
    POL_WORST = 2'd1,
    POL_FIRST = 2'd2
  } fit_t;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [15:0]   request_bytes;
    logic [AW-1:0] user_offset_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [AW-1:0] user_offset_out;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CMD, S_A_RD, S_A_CHK, S_A_FIN, S_A_W2,
    S_F_TAG, S_F_RD, S_F_ADV, S_F_INS, S_F_MR, S_F_W, S_F_W2, S_DONE
  } state_t;

endpackage
`default_nettype wire

[rtl/core/free_list_heap_allocator.sv]
// Channel  Direction  Handshake             Word
// in_      input      in_valid / in_ready   cmd, request_bytes, user_offset_in
// out_     output     out_valid / out_ready status, user_offset_out
// cfg      input      psel / penable        fit_policy at addresses 0 to 3 (paddr[2] low)
// An allocate walks the free list, visiting each free chunk through one registered read port
// of the chunk memories; first fit stops at the first chunk that fits.
// A free walks the free list past every free chunk below the freed block.
// Init, and reset, sweep the tag memory; no word is taken then.
// A finished result waits in the output register while out_ready is low.
`default_nettype none
module free_list_heap_allocator (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  flha_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  wire                 out_ready,
  output flha_pkg::out_word_t out_word,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import flha_pkg::*;

  logic [LW-1:0] len_mem [HEAP_BYTES];
  logic [LW-1:0] link_mem [HEAP_BYTES];
  logic          tag_mem [HEAP_BYTES];
  logic [LW-1:0] len_q, link_q;
  logic          tag_q;

  logic          len_we, link_we, tag_we, tag_wd;
  logic [AW-1:0] len_wa, link_wa, tag_wa, rd_addr;
  logic [LW-1:0] len_wd, link_wd;

  state_t        state_r, state_nxt;
  logic [1:0]    fit_r, cmd_r;
  logic [15:0]   req_r;
  logic [AW-1:0] uoff_r, blk_r, blk_nxt, off_r, off_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, steps_r, steps_nxt;
  logic [LW-1:0] pick_r, pick_nxt, pprev_r, pprev_nxt, plen_r, plen_nxt;
  logic [LW-1:0] plink_r, plink_nxt, head_r, head_nxt, join_r, join_nxt;
  logic [LW-1:0] flen_r, flen_nxt, prlen_r, prlen_nxt, nlen_r, nlen_nxt;
  logic [LW-1:0] nlink_r, nlink_nxt, clr_r, clr_nxt;
  logic          reply_r, reply_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  logic [16:0]   need;
  logic          fits, first_fit;
  logic [LW-1:0] remain;
  logic [13:0]   rest, prev_end, blk_end;

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    len_q  <= len_mem[rd_addr];
    link_q <= link_mem[rd_addr];
    tag_q  <= tag_mem[rd_addr];
  end

  assign need      = {1'b0, req_r} + 17'(HEADER_BYTES);
  assign fits      = {4'b0, len_q} >= need;
  assign first_fit = fit_r[1];
  assign remain    = plen_r - need[LW-1:0];
  assign rest      = {1'b0, pick_r} + {1'b0, need[LW-1:0]};
  assign prev_end  = {1'b0, prev_r} + {1'b0, prlen_r};
  assign blk_end   = {2'b0, blk_r} + {1'b0, flen_r};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign pready    = 1'b1;
  assign prdata    = {30'b0, fit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
      fit_r       <= POL_BEST;
      head_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      if (psel && penable && pwrite && !paddr[2]) begin
        fit_r <= pwdata[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_word.cmd;
      req_r  <= in_word.request_bytes;
      uoff_r <= in_word.user_offset_in;
    end
    out_word_r <= out_word_nxt;
    blk_r   <= blk_nxt;   off_r   <= off_nxt;   stat_r  <= stat_nxt;
    cur_r   <= cur_nxt;   prev_r  <= prev_nxt;  steps_r <= steps_nxt;
    pick_r  <= pick_nxt;  pprev_r <= pprev_nxt; plen_r  <= plen_nxt;
    plink_r <= plink_nxt; join_r  <= join_nxt;  flen_r  <= flen_nxt;
    prlen_r <= prlen_nxt; nlen_r  <= nlen_nxt;  nlink_r <= nlink_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;        reply_nxt = reply_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt = out_word_r;
    head_nxt = head_r;
    blk_nxt = blk_r;   off_nxt = off_r;     stat_nxt = stat_r;
    cur_nxt = cur_r;   prev_nxt = prev_r;   steps_nxt = steps_r;
    pick_nxt = pick_r; pprev_nxt = pprev_r; plen_nxt = plen_r;
    plink_nxt = plink_r; join_nxt = join_r; flen_nxt = flen_r;
    prlen_nxt = prlen_r; nlen_nxt = nlen_r; nlink_nxt = nlink_r;
    len_we = 1'b0;  len_wa = '0;  len_wd = '0;
    link_we = 1'b0; link_wa = '0; link_wd = '0;
    tag_we = 1'b0;  tag_wa = '0;  tag_wd = 1'b0;
    rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CMD;
      end
      S_CLR: begin
        tag_we = 1'b1;
        tag_wa = clr_r[AW-1:0];
        if (clr_r == '0) begin
          len_we = 1'b1;  len_wd = INIT_LEN;
          link_we = 1'b1; link_wd = NULL_LINK;
          head_nxt = '0;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LW'(HEAP_BYTES - 1)) begin
          clr_nxt = '0;
          stat_nxt = ST_OK;
          off_nxt = '0;
          state_nxt = reply_r ? S_DONE : S_IDLE;
        end
      end
      S_CMD: begin
        stat_nxt = ST_OK;
        off_nxt = '0;
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_INIT: begin
            reply_nxt = 1'b1;
            state_nxt = S_CLR;
          end
          CMD_ALLOC: begin
            if (req_r == '0) begin
              stat_nxt = ST_BAD_SZ;
            end else begin
              cur_nxt = head_r; prev_nxt = NULL_LINK; pick_nxt = NULL_LINK;
              pprev_nxt = NULL_LINK; steps_nxt = '0;
              state_nxt = S_A_RD;
            end
          end
          CMD_FREE: begin
            if (uoff_r == '0) begin
              stat_nxt = ST_OK;
            end else if (uoff_r < AW'(HEADER_BYTES)) begin
              stat_nxt = ST_BAD_PTR;
            end else begin
              blk_nxt = uoff_r - AW'(HEADER_BYTES);
              rd_addr = blk_nxt;
              state_nxt = S_F_TAG;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_A_RD: begin
        rd_addr = cur_r[AW-1:0];
        state_nxt = (cur_r[AW] || steps_r[AW]) ? S_A_FIN : S_A_CHK;
      end
      S_A_CHK: begin
        steps_nxt = steps_r + 1'b1;
        prev_nxt = cur_r;
        cur_nxt = link_q;
        state_nxt = S_A_RD;
        if (fits) begin
          if (pick_r[AW]) begin
            pick_nxt = cur_r; pprev_nxt = prev_r; plen_nxt = len_q; plink_nxt = link_q;
            if (first_fit) state_nxt = S_A_FIN;
          end else if ((fit_r == POL_BEST && len_q < plen_r) ||
                       (fit_r == POL_WORST && len_q > plen_r)) begin
            pick_nxt = cur_r; pprev_nxt = prev_r; plen_nxt = len_q; plink_nxt = link_q;
          end
        end
      end
      S_A_FIN: begin
        if (pick_r[AW]) begin
          stat_nxt = ST_NO_FIT;
          state_nxt = S_DONE;
        end else begin
          join_nxt = plink_r;
          if (remain >= LW'(NODE_BYTES) && rest < 14'(HEAP_BYTES)) begin
            len_we = 1'b1;  len_wa = rest[AW-1:0];  len_wd = remain;
            link_we = 1'b1; link_wa = rest[AW-1:0]; link_wd = plink_r;
            join_nxt = rest[LW-1:0];
          end
          tag_we = 1'b1; tag_wa = pick_r[AW-1:0]; tag_wd = 1'b1;
          state_nxt = S_A_W2;
        end
      end
      S_A_W2: begin
        len_we = 1'b1; len_wa = pick_r[AW-1:0]; len_wd = req_r[LW-1:0];
        if (!pprev_r[AW]) begin
          link_we = 1'b1; link_wa = pprev_r[AW-1:0]; link_wd = join_r;
        end else begin
          head_nxt = join_r;
        end
        off_nxt = pick_r[AW-1:0] + AW'(HEADER_BYTES);
        stat_nxt = ST_OK;
        state_nxt = S_DONE;
      end
      S_F_TAG: begin
        if (!tag_q) begin
          stat_nxt = ST_BAD_PTR;
          state_nxt = S_DONE;
        end else begin
          tag_we = 1'b1; tag_wa = blk_r; tag_wd = 1'b0;
          flen_nxt = len_q + LW'(HEADER_BYTES);
          cur_nxt = head_r; prev_nxt = NULL_LINK; steps_nxt = '0;
          state_nxt = S_F_RD;
        end
      end
      S_F_RD: begin
        rd_addr = cur_r[AW-1:0];
        if (!cur_r[AW] && cur_r[AW-1:0] < blk_r && !steps_r[AW]) state_nxt = S_F_ADV;
        else state_nxt = S_F_INS;
      end
      S_F_ADV: begin
        prev_nxt = cur_r;
        prlen_nxt = len_q;
        cur_nxt = link_q;
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_F_RD;
      end
      S_F_INS: begin
        if (cur_r[AW]) cur_nxt = NULL_LINK;
        rd_addr = cur_r[AW-1:0];
        state_nxt = S_F_MR;
      end
      S_F_MR: begin
        if (!cur_r[AW] && blk_end == {1'b0, cur_r}) begin
          nlen_nxt = flen_r + len_q;
          nlink_nxt = link_q;
        end else begin
          nlen_nxt = flen_r;
          nlink_nxt = cur_r;
        end
        state_nxt = S_F_W;
      end
      S_F_W: begin
        if (!prev_r[AW] && prev_end == {2'b0, blk_r}) begin
          len_we = 1'b1;  len_wa = prev_r[AW-1:0];  len_wd = prlen_r + nlen_r;
          link_we = 1'b1; link_wa = prev_r[AW-1:0]; link_wd = nlink_r;
          stat_nxt = ST_OK;
          state_nxt = S_DONE;
        end else begin
          len_we = 1'b1;  len_wa = blk_r;  len_wd = nlen_r;
          link_we = 1'b1; link_wa = blk_r; link_wd = nlink_r;
          state_nxt = S_F_W2;
        end
      end
      S_F_W2: begin
        if (!prev_r[AW]) begin
          link_we = 1'b1; link_wa = prev_r[AW-1:0]; link_wd = {1'b0, blk_r};
        end else begin
          head_nxt = {1'b0, blk_r};
        end
        stat_nxt = ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt.status = stat_r;
          out_word_nxt.user_offset_out = off_r;
          reply_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/flha_chk.sv]
`default_nettype none
module flha_chk (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input flha_pkg::out_word_t out_word,
  input wire                 psel,
  input wire                 penable,
  input wire                 pwrite,
  input wire [2:0]           paddr,
  input wire [31:0]          pwdata,
  input wire [31:0]          prdata,
  input wire                 pready
);
  import flha_pkg::*;
`include "free_list_heap_allocator_assert.svh"

  `FLHA_ASSERT_NOW(a_pready_high, 1'b1, pready)
  `FLHA_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready)
  `FLHA_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_word))
  `FLHA_ASSERT_NOW(a_fail_zero_offset, out_valid && out_word.status != ST_OK,
                   out_word.user_offset_out == '0)
  `FLHA_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && !paddr[2],
                    prdata[1:0] == $past(pwdata[1:0]))

endmodule

bind free_list_heap_allocator flha_chk u_flha_chk (.*);
`default_nettype wire
